FILE: hdl/pwl_gray_pkg.sv
`timescale 1ns / 1ps

package pwl_gray_pkg;

  localparam int GrayW   = 8;
  localparam int ProdW   = 2 * GrayW;
  localparam int IndexW  = 3;
  localparam int DivSteps = GrayW;

  localparam logic [GrayW-1:0] GRAY_MAX = 8'd255;

  // Configuration register indexes
  typedef enum logic [IndexW-1:0] {
    REG_BREAK1_IN  = 3'd0,
    REG_BREAK2_IN  = 3'd1,
    REG_BREAK1_OUT = 3'd2,
    REG_BREAK2_OUT = 3'd3
  } pwl_reg_t;

  // Segment setup: rise magnitude and sign, run, span and base level
  typedef struct packed {
    logic             neg;
    logic [GrayW-1:0] mag;
    logic [GrayW-1:0] run;
    logic [GrayW-1:0] span;
    logic [GrayW-1:0] base;
    logic             rej;
  } pwl_seg_t;

  // One step of the restoring divider
  typedef struct packed {
    logic             neg;
    logic [ProdW-1:0] rem;
    logic [GrayW-1:0] quo;
    logic [GrayW-1:0] span;
    logic [GrayW-1:0] base;
    logic             rej;
  } pwl_div_t;

endpackage

FILE: hdl/piecewise_linear_gray_map_top.sv
`timescale 1ns / 1ps

// Piecewise linear contrast stretch for an 8-bit gray pixel stream.
// Input channel (in_valid/in_ready/in_pixel_gray) takes one pixel per
// transaction; the result channel (out_valid/out_ready/out_mapped_gray,
// out_rejected) returns exactly one transaction per pixel, in order.
// Breakpoints are set through the cfg_ write port (index 0..3: break1_in,
// break2_in, break1_out, break2_out); other indexes are dropped. Write them
// only while the pipeline is empty.
// Throughput: one pixel per clock while the receiver does not stall; the
// depth is set by the 8x8 multiply stage and the eight one-bit stages of
// the restoring divider that follows it.
// When break1_in exceeds break2_in every result carries rejected = 1 and a
// gray level of 0.
// Reset (synchronous, rst_n low) empties the pipeline and loads the
// identity line (0,0)-(255,255).
// When the receiver stalls, each stage holds its item until the next one
// frees up; bubbles still close, so in_ready drops only once every stage
// holds an item.
module piecewise_linear_gray_map_top
  import pwl_gray_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IndexW-1:0] cfg_index,
  input  logic [GrayW-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [GrayW-1:0]  in_pixel_gray,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [GrayW-1:0]  out_mapped_gray,
  output logic              out_rejected
);

  // Configuration registers
  logic [GrayW-1:0] break1_in_r, break2_in_r, break1_out_r, break2_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break1_in_r  <= '0;
      break2_in_r  <= GRAY_MAX;
      break1_out_r <= '0;
      break2_out_r <= GRAY_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BREAK1_IN:  break1_in_r  <= cfg_data;
        REG_BREAK2_IN:  break2_in_r  <= cfg_data;
        REG_BREAK1_OUT: break1_out_r <= cfg_data;
        REG_BREAK2_OUT: break2_out_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline registers and valid bits
  pwl_seg_t          s0_r, s0_nxt;
  logic              s0_vld_r;
  pwl_div_t          div_r   [0:DivSteps];
  pwl_div_t          div_nxt [0:DivSteps];
  logic [DivSteps:0] div_vld_r;
  logic [GrayW-1:0]  mapped_r, mapped_nxt;
  logic              rej_r;
  logic              out_vld_r;

  // Load enables: a stage loads when it is empty or its successor loads
  logic              s0_ld;
  logic [DivSteps:0] div_ld;
  logic              out_ld;

  always_comb begin
    out_ld = !out_vld_r || out_ready;
    div_ld[DivSteps] = !div_vld_r[DivSteps] || out_ld;
    for (int k = DivSteps - 1; k >= 0; k--) begin
      div_ld[k] = !div_vld_r[k] || div_ld[k+1];
    end
    s0_ld = !s0_vld_r || div_ld[0];
  end

  assign in_ready = s0_ld;

  // Stage 0: pick the segment. Degenerate cases (rejected, zero first span)
  // become a zero rise over a span of one so the divider yields 0.
  always_comb begin
    s0_nxt      = '0;
    s0_nxt.span = 8'd1;
    if (break1_in_r > break2_in_r) begin
      s0_nxt.rej = 1'b1;
    end else if (in_pixel_gray <= break1_in_r) begin
      if (break1_in_r == '0) begin
        s0_nxt.base = break1_out_r;
      end else begin
        s0_nxt.mag  = break1_out_r;
        s0_nxt.run  = in_pixel_gray;
        s0_nxt.span = break1_in_r;
      end
    end else if (in_pixel_gray <= break2_in_r) begin
      s0_nxt.neg  = break2_out_r < break1_out_r;
      s0_nxt.mag  = s0_nxt.neg ? (break1_out_r - break2_out_r)
                               : (break2_out_r - break1_out_r);
      s0_nxt.run  = in_pixel_gray - break1_in_r;
      s0_nxt.span = break2_in_r - break1_in_r;
      s0_nxt.base = break1_out_r;
    end else begin
      s0_nxt.mag  = GRAY_MAX - break2_out_r;
      s0_nxt.run  = in_pixel_gray - break2_in_r;
      s0_nxt.span = GRAY_MAX - break2_in_r;
      s0_nxt.base = break2_out_r;
    end
  end

  // Stage 1: magnitude of rise * run
  always_comb begin
    div_nxt[0].neg  = s0_r.neg;
    div_nxt[0].rem  = {{GrayW{1'b0}}, s0_r.mag} * {{GrayW{1'b0}}, s0_r.run};
    div_nxt[0].quo  = '0;
    div_nxt[0].span = s0_r.span;
    div_nxt[0].base = s0_r.base;
    div_nxt[0].rej  = s0_r.rej;
  end

  // Divider: one quotient bit per stage, MSB first. Run never exceeds span,
  // so the quotient fits in eight bits.
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Sh = DivSteps - 1 - j;
    logic [ProdW-1:0] dsor;
    logic             ge;

    always_comb begin
      dsor         = {{GrayW{1'b0}}, div_r[j].span} << Sh;
      ge           = div_r[j].rem >= dsor;
      div_nxt[j+1] = div_r[j];
      if (ge) begin
        div_nxt[j+1].rem = div_r[j].rem - dsor;
      end
      div_nxt[j+1].quo[Sh] = ge;
    end
  end

  // Last stage: apply sign, add base, clamp to 0..255
  logic signed [GrayW+1:0] sum;

  always_comb begin
    if (div_r[DivSteps].neg) begin
      sum = signed'({2'b00, div_r[DivSteps].base}) - signed'({2'b00, div_r[DivSteps].quo});
    end else begin
      sum = signed'({2'b00, div_r[DivSteps].base}) + signed'({2'b00, div_r[DivSteps].quo});
    end
    if (sum[GrayW+1]) begin
      mapped_nxt = '0;
    end else if (sum[GrayW]) begin
      mapped_nxt = GRAY_MAX;
    end else begin
      mapped_nxt = sum[GrayW-1:0];
    end
  end

  // Valid bits: advance with the loads, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      div_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (s0_ld) begin
        s0_vld_r <= in_valid;
      end
      if (div_ld[0]) begin
        div_vld_r[0] <= s0_vld_r;
      end
      for (int k = 1; k <= DivSteps; k++) begin
        if (div_ld[k]) begin
          div_vld_r[k] <= div_vld_r[k-1];
        end
      end
      if (out_ld) begin
        out_vld_r <= div_vld_r[DivSteps];
      end
    end
  end

  // Payload: hold while the stage is stalled
  always_ff @(posedge clk) begin
    if (s0_ld) begin
      s0_r <= s0_nxt;
    end
    for (int k = 0; k <= DivSteps; k++) begin
      if (div_ld[k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
    if (out_ld) begin
      mapped_r <= mapped_nxt;
      rej_r    <= div_r[DivSteps].rej;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_mapped_gray = mapped_r;
  assign out_rejected    = rej_r;

  // A segment never reaches the divider with an empty span
  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s0_vld_r |-> (s0_r.span != '0))
    else $error("zero span entered divider");

  // After the last step the remainder is below the divisor
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld_r[DivSteps] |-> (div_r[DivSteps].rem < {{GrayW{1'b0}}, div_r[DivSteps].span}))
    else $error("divider remainder not reduced");

  // A rejected result always carries gray level zero
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && rej_r) |-> (mapped_r == '0))
    else $error("rejected result with nonzero level");

  // Backpressure reaches the input only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s0_vld_r && (&div_vld_r) && out_vld_r && !out_ready))
    else $error("input stalled with a bubble in the pipeline");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pwl_gray_pkg::*;

  localparam int RegCount      = 4;     // registers 0..3; higher indexes are dropped
  localparam int LatencyGuard  = 16;    // pipeline is 11 deep, leave some margin
  localparam int WatchdogLimit = 4000;  // cycles without any transaction
  localparam int MaxReports    = 10;
  localparam int RandomPhases  = 12;
  localparam int PhaseItems    = 50;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [GrayW-1:0] gray;
    logic             rejected;
  } gray_result_t;

  // DUT inputs, all known from time zero
  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic [IndexW-1:0] cfg_index     = '0;
  logic [GrayW-1:0]  cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic [GrayW-1:0]  in_pixel_gray = '0;
  logic              out_ready     = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [GrayW-1:0]  out_mapped_gray;
  logic              out_rejected;

  // Shadow copy of the breakpoint registers, indexed by register code
  logic [GrayW-1:0] break_lvl [RegCount];

  logic [GrayW-1:0] pending_pixels [$];
  gray_result_t     expected_maps  [$];

  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int mismatch_count  = 0;
  int pixels_sent     = 0;
  int maps_checked    = 0;
  int rejected_seen   = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;

  piecewise_linear_gray_map_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_gray   (in_pixel_gray),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mapped_gray (out_mapped_gray),
    .out_rejected    (out_rejected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Map one pixel through the three-segment line using the shadow registers.
  // SV int division truncates toward zero, which matches a negative rise.
  function automatic gray_result_t map_gray(logic [GrayW-1:0] pix);
    gray_result_t r;
    int g, xa, xb, ya, yb, t;
    g  = int'(pix);
    xa = int'(break_lvl[REG_BREAK1_IN]);
    xb = int'(break_lvl[REG_BREAK2_IN]);
    ya = int'(break_lvl[REG_BREAK1_OUT]);
    yb = int'(break_lvl[REG_BREAK2_OUT]);
    r.gray = '0;
    r.rejected = 1'b0;
    // Breakpoints out of order: every pixel is rejected with level zero
    if (xa > xb) begin
      r.rejected = 1'b1;
      return r;
    end
    if (g <= xa) begin
      // First segment with no width only happens for pixel 0: give break1_out
      if (xa == 0) t = ya;
      else t = (ya * g) / xa;
    end else if (g <= xb) begin
      t = ((yb - ya) * (g - xa)) / (xb - xa) + ya;
    end else begin
      t = ((int'(GRAY_MAX) - yb) * (g - xb)) / (int'(GRAY_MAX) - xb) + yb;
    end
    if (t < 0) t = 0;
    if (t > int'(GRAY_MAX)) t = int'(GRAY_MAX);
    r.gray = t[GrayW-1:0];
    return r;
  endfunction

  // Register write: shadow updated for indexes that exist
  task automatic write_reg(int idx, logic [GrayW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[IndexW-1:0];
    cfg_data  <= val;
    if (idx < RegCount) break_lvl[idx] = val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Wait for every queued pixel to go out and every result to come back,
  // then let the pipeline settle before anything is reconfigured.
  task automatic drain_pipe();
    while (pending_pixels.size() != 0 || in_valid || expected_maps.size() != 0)
      @(posedge clk);
    repeat (LatencyGuard) @(posedge clk);
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;  stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 76; stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;  stall_pct = 76;
      end
      default: begin
        send_idle_pct = 25; stall_pct = 25;
      end
    endcase
  endtask

  // Gray level biased toward the ends of the range
  function automatic logic [GrayW-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 40) return GRAY_MAX;
    return GrayW'($urandom);
  endfunction

  // Pixel biased toward the breakpoints and the range ends
  function automatic logic [GrayW-1:0] pick_pixel();
    int r, base;
    r = $urandom_range(99);
    if (r < 60) return GrayW'($urandom);
    if (r < 70) return (r[0]) ? GRAY_MAX : '0;
    base = (r < 85) ? int'(break_lvl[REG_BREAK1_IN]) : int'(break_lvl[REG_BREAK2_IN]);
    base = base + $urandom_range(2) - 1;
    if (base < 0) base = 0;
    if (base > int'(GRAY_MAX)) base = int'(GRAY_MAX);
    return base[GrayW-1:0];
  endfunction

  task automatic report_mismatch(string what, int exp_v, int act_v);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("mismatch %0d at %0t ns: %s expected %0d got %0d",
               mismatch_count, $realtime, what, exp_v, act_v);
  endtask

  // Driver: hold the transaction until accepted, then advance to the next
  // pending pixel or idle. Each transaction accepted here queues its result.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_maps.push_back(map_gray(in_pixel_gray));
        pixels_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold valid and payload
      end else if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        in_pixel_gray <= pending_pixels.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation,
  // and stall the result channel at random.
  always @(posedge clk) begin
    gray_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          report_mismatch("unexpected result, gray", -1, int'(out_mapped_gray));
        end else begin
          want = expected_maps.pop_front();
          maps_checked++;
          if (out_rejected) rejected_seen++;
          if (out_mapped_gray !== want.gray)
            report_mismatch("mapped_gray", int'(want.gray), int'(out_mapped_gray));
          if (out_rejected !== want.rejected)
            report_mismatch("rejected", int'(want.rejected), int'(out_rejected));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: count cycles with no transaction on either channel and no config write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired after %0d idle cycles, %0d results outstanding",
               quiet_cycles, expected_maps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [GrayW-1:0] x1, x2;
    // Shadow starts at the reset line (0,0)-(255,255)
    break_lvl[REG_BREAK1_IN]  = '0;
    break_lvl[REG_BREAK2_IN]  = GRAY_MAX;
    break_lvl[REG_BREAK1_OUT] = '0;
    break_lvl[REG_BREAK2_OUT] = GRAY_MAX;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Identity line from reset, range ends and alternating bit patterns
    set_idling(IDLE_NONE);
    pending_pixels.push_back(8'd0);
    pending_pixels.push_back(8'd1);
    pending_pixels.push_back(8'd128);
    pending_pixels.push_back(8'd254);
    pending_pixels.push_back(8'd255);
    pending_pixels.push_back(8'h55);
    pending_pixels.push_back(8'hAA);
    drain_pipe();

    // First segment with no width: pixel 0 must give break1_out
    write_reg(REG_BREAK1_OUT, 8'd200);
    end_writes();
    set_idling(IDLE_RECEIVER);
    pending_pixels.push_back(8'd0);
    pending_pixels.push_back(8'd1);
    pending_pixels.push_back(8'd255);
    drain_pipe();

    // Equal breakpoints: empty middle segment, above it use the last one
    write_reg(REG_BREAK1_IN,  8'd100);
    write_reg(REG_BREAK2_IN,  8'd100);
    write_reg(REG_BREAK1_OUT, 8'd50);
    write_reg(REG_BREAK2_OUT, 8'd200);
    end_writes();
    set_idling(IDLE_SENDER);
    pending_pixels.push_back(8'd0);
    pending_pixels.push_back(8'd99);
    pending_pixels.push_back(8'd100);
    pending_pixels.push_back(8'd101);
    pending_pixels.push_back(8'd255);
    drain_pipe();

    // Breakpoints out of order: rejected with level zero
    write_reg(REG_BREAK1_IN, 8'd200);
    end_writes();
    set_idling(IDLE_BOTH);
    pending_pixels.push_back(8'd0);
    pending_pixels.push_back(8'd150);
    pending_pixels.push_back(8'd255);
    drain_pipe();

    // Falling middle segment, then writes to indexes past the last register
    // that must leave the line unchanged
    write_reg(REG_BREAK1_IN,  8'd10);
    write_reg(REG_BREAK2_IN,  8'd250);
    write_reg(REG_BREAK1_OUT, 8'd255);
    write_reg(REG_BREAK2_OUT, 8'd0);
    for (int i = 0; i < (1 << IndexW) - RegCount; i++)
      write_reg(RegCount + i, GrayW'($urandom));
    end_writes();
    set_idling(IDLE_NONE);
    pending_pixels.push_back(8'd10);
    pending_pixels.push_back(8'd128);
    pending_pixels.push_back(8'd251);
    drain_pipe();

    // Random part: a new line per phase, idling mode rotating through all four
    for (int p = 0; p < RandomPhases; p++) begin
      x1 = pick_level();
      x2 = pick_level();
      // Mostly ordered breakpoints, one phase in five left as drawn
      if ($urandom_range(4) != 0 && x1 > x2) begin
        x1 = x1 ^ x2;
        x2 = x1 ^ x2;
        x1 = x1 ^ x2;
      end
      write_reg(REG_BREAK1_IN,  x1);
      write_reg(REG_BREAK2_IN,  x2);
      write_reg(REG_BREAK1_OUT, pick_level());
      write_reg(REG_BREAK2_OUT, pick_level());
      if ($urandom_range(3) == 0)
        write_reg(RegCount + $urandom_range((1 << IndexW) - RegCount - 1), GrayW'($urandom));
      end_writes();
      set_idling(idle_mode_t'(p % 4));
      for (int i = 0; i < PhaseItems; i++) begin
        pending_pixels.push_back(pick_pixel());
        // Hold off the sender mid-phase until every result is back
        if (p % 4 == 1 && i == PhaseItems / 2 - 1) drain_pipe();
      end
      drain_pipe();
    end

    if (expected_maps.size() != 0)
      report_mismatch("results left over", 0, expected_maps.size());

    $display("coverage: %0d pixels sent, %0d results checked, %0d of them rejected",
             pixels_sent, maps_checked, rejected_seen);
    $display("coverage: %0d breakpoint settings under four idle/stall modes, %0d mismatches",
             settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/pwl_gray_pkg.sv
hdl/piecewise_linear_gray_map_top.sv
tb/tb.sv
